// ----- sv/gnr_pkg.sv -----
// ----------------------------------------------------------------------------
// gnr_pkg: shared types, codes and helpers of the grid relaxation block
// Holds the grid geometry, request codes, state encoding and small
// arithmetic helpers used by the controller.
// ----------------------------------------------------------------------------
package gnr_pkg;

  localparam int MAX_WIDTH  = 16;
  localparam int MAX_HEIGHT = 16;
  localparam int VALUE_BITS = 32;
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT);
  localparam int AW         = XW + YW;
  localparam int NCELLS     = MAX_WIDTH * MAX_HEIGHT;
  localparam int SHARE_BITS = VALUE_BITS + 1;
  localparam int ACC_BITS   = SHARE_BITS + 3;
  localparam int SUM_BITS   = ACC_BITS + 1;

  localparam logic [2:0] REQ_WR_VALUE  = 3'd0;
  localparam logic [2:0] REQ_WR_TARGET = 3'd1;
  localparam logic [2:0] REQ_RD_VALUE  = 3'd2;
  localparam logic [2:0] REQ_UPDATE    = 3'd3;
  localparam logic [2:0] REQ_PUSH      = 3'd4;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_MAX    = 2'd2;
  localparam logic [1:0] CFG_WRAP   = 2'd3;

  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_DEC  = 2'd1;
  localparam logic [1:0] STEP_INC  = 2'd2;

  typedef logic signed [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    value_t value;
    value_t target;
    value_t delta;
    value_t push;
  } cell_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_REQ_RD, ST_REQ_WB, ST_U_RD, ST_U_WR,
    ST_P1_RD, ST_P1_LD, ST_P1_DIV, ST_P1_WR, ST_P2, ST_P2_WR, ST_FIN
  } state_t;

  // Grid size register to the size actually used: zero means one.
  function automatic logic [4:0] eff_size(input logic [4:0] s, input logic [4:0] lim);
    logic [4:0] r;
    if (s == 5'd0) r = 5'd1;
    else if (s > lim) r = lim;
    else r = s;
    return r;
  endfunction

  // Clamp a wide signed sum to the value range.
  function automatic value_t sat_value(input logic signed [SUM_BITS-1:0] s);
    value_t r;
    if (s > SUM_BITS'(signed'({1'b0, {(VALUE_BITS-1){1'b1}}})))
      r = {1'b0, {(VALUE_BITS-1){1'b1}}};
    else if (s < -SUM_BITS'(signed'({1'b0, 1'b1, {(VALUE_BITS-1){1'b0}}})))
      r = {1'b1, {(VALUE_BITS-1){1'b0}}};
    else
      r = s[VALUE_BITS-1:0];
    return r;
  endfunction

  // Column and row step of each of the eight stencil directions.
  function automatic logic [1:0] dir_dx(input logic [2:0] k);
    logic [1:0] r;
    unique case (k)
      3'd0, 3'd3, 3'd5: r = STEP_DEC;
      3'd2, 3'd4, 3'd7: r = STEP_INC;
      default:          r = STEP_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] dir_dy(input logic [2:0] k);
    logic [1:0] r;
    unique case (k)
      3'd0, 3'd1, 3'd2: r = STEP_DEC;
      3'd5, 3'd6, 3'd7: r = STEP_INC;
      default:          r = STEP_NONE;
    endcase
    return r;
  endfunction

  // One coordinate step; bit 5 tells whether the neighbor exists.
  function automatic logic [5:0] step_coord(input logic [4:0] p, input logic [4:0] lim,
                                            input logic [1:0] st, input logic wrap);
    logic [5:0] r;
    r = {1'b1, p};
    if (st == STEP_DEC) begin
      if (p == 5'd0) r = {wrap, lim - 5'd1};
      else r = {1'b1, p - 5'd1};
    end else if (st == STEP_INC) begin
      if (p == lim - 5'd1) r = {wrap, 5'd0};
      else r = {1'b1, p + 5'd1};
    end
    return r;
  endfunction

  // Number of stencil neighbors, copies counted.
  function automatic logic [3:0] degree(input logic [4:0] x, input logic [4:0] y,
                                        input logic [4:0] w, input logic [4:0] h,
                                        input logic wrap);
    logic [1:0] cx, cy;
    logic [3:0] r;
    cx = 2'd1 + 2'(x != 5'd0) + 2'(x != w - 5'd1);
    cy = 2'd1 + 2'(y != 5'd0) + 2'(y != h - 5'd1);
    if (wrap) r = 4'd8;
    else r = 4'({2'b00, cx} * {2'b00, cy}) - 4'd1;
    return r;
  endfunction

endpackage

// ----- sv/gnr_ram.sv -----
// ----------------------------------------------------------------------------
// gnr_ram: simple dual-port synchronous memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gnr_ram import gnr_pkg::*; #(
  parameter int W = VALUE_BITS
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [NCELLS];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/gnr_div.sv -----
// ----------------------------------------------------------------------------
// gnr_div: unsigned divider by a small divisor
// Restoring division of a 32-bit magnitude by 1..8, eight quotient bits
// per cycle while busy, with done raised in the cycle after the last step.
// ----------------------------------------------------------------------------
module gnr_div import gnr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [3:0]            divisor,
  output logic [VALUE_BITS-1:0] quotient,
  output logic                  done
);

  localparam int STEPS = VALUE_BITS / 8;

  logic [VALUE_BITS-1:0]    q;
  logic [2:0]               rem;
  logic [3:0]               d;
  logic                     busy;
  logic [$clog2(STEPS)-1:0] cnt;
  logic [7:0]               qb;
  logic [2:0]               rem_next;

  always_comb begin
    logic [3:0] t;
    logic [2:0] r;
    r = rem;
    for (int i = 0; i < 8; i++) begin
      t = {r, q[VALUE_BITS-1-i]};
      if (t >= d) begin
        t = t - d;
        qb[7-i] = 1'b1;
      end else begin
        qb[7-i] = 1'b0;
      end
      r = t[2:0];
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ($clog2(STEPS))'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      d   <= divisor;
    end else if (busy) begin
      q   <= {q[VALUE_BITS-9:0], qb};
      rem <= rem_next;
    end
  end

  assign quotient = q;

endmodule

// ----- sv/grid_neighbor_relaxation_top.sv -----
// ----------------------------------------------------------------------------
// grid_neighbor_relaxation_top: 16x16 cell relaxation engine
// Cell state in one memory, neighbor shares in a second, run by a sweep
// controller with a small divider.
// ----------------------------------------------------------------------------
// One request is taken at a time. After reset the block clears all 256
// cells of the cell memory and does not take a beat on the request channel
// until that pass ends. Writes and reads of a single cell go through a read
// of the cell word from memory, a merged write back (for a read, capture of
// the value) and the result beat. An update sweeps the active cells, each by
// a memory read, then the clamped sum written back. A push runs two sweeps:
// the first reads each cell's delta and divides it by the cell's neighbor
// count in the divider, storing the outgoing share; the second gathers the
// shares of the cell's up to eight neighbors from the share memory, one read
// per cycle, and writes the new push. The result register lets the next
// request be taken while a finished result beat waits on the output side.
// Configuration is written through cfg_we, cfg_index and cfg_data and
// must only change while no request is in flight.
module grid_neighbor_relaxation_top import gnr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            req_type,
  input  logic [3:0]            cell_x,
  input  logic [3:0]            cell_y,
  input  logic signed [31:0]    write_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [31:0]    read_value,
  output logic                  done_res,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [30:0]           cfg_data
);

  // Configuration registers.
  logic [4:0]  grid_width, grid_height;
  logic [30:0] mag_limit;
  logic        wrap_edges;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= 5'd16;
      grid_height <= 5'd16;
      mag_limit   <= 31'd65536;
      wrap_edges  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  grid_width  <= cfg_data[4:0];
        CFG_HEIGHT: grid_height <= cfg_data[4:0];
        CFG_MAX:    mag_limit   <= cfg_data;
        CFG_WRAP:   wrap_edges  <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  logic [4:0] w_eff, h_eff;
  assign w_eff = eff_size(grid_width, 5'(MAX_WIDTH));
  assign h_eff = eff_size(grid_height, 5'(MAX_HEIGHT));

  // Controller registers.
  state_t state, state_next;
  logic [XW-1:0] x, x_next;
  logic [YW-1:0] y, y_next;
  logic [2:0]    req, req_next;
  value_t        wval, wval_next;
  value_t        res, res_next;
  logic [3:0]    k, k_next;
  logic signed [ACC_BITS-1:0]   acc, acc_next;
  logic          sv, sv_next;
  logic signed [SHARE_BITS-1:0] share, share_next;
  logic          dneg, dneg_next;
  logic          out_load;

  // Memories and divider.
  cell_word_t cell_rd, cell_wd;
  logic       cell_we;
  logic [SHARE_BITS-1:0] share_rd;
  logic       share_we;
  logic [AW-1:0] nb_addr;
  logic       div_start, div_done;
  logic [VALUE_BITS-1:0] div_q, div_n;
  logic [3:0] deg;

  gnr_ram #(.W($bits(cell_word_t))) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr ({y, x}),
    .wdata (cell_wd),
    .raddr ({y, x}),
    .rdata (cell_rd)
  );

  gnr_ram #(.W(SHARE_BITS)) u_share_ram (
    .clk   (clk),
    .we    (share_we),
    .waddr ({y, x}),
    .wdata (share),
    .raddr (nb_addr),
    .rdata (share_rd)
  );

  gnr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (deg),
    .quotient (div_q),
    .done     (div_done)
  );

  // Sweep position helpers.
  logic last_active, last_full;
  logic [XW-1:0] x_adv;
  logic [YW-1:0] y_adv;
  assign last_active = ({1'b0, x} == w_eff - 5'd1) && ({1'b0, y} == h_eff - 5'd1);
  assign last_full   = (x == {XW{1'b1}}) && (y == {YW{1'b1}});

  always_comb begin
    if ({1'b0, x} == w_eff - 5'd1) begin
      x_adv = '0;
      y_adv = y + 1'b1;
    end else begin
      x_adv = x + 1'b1;
      y_adv = y;
    end
  end

  assign deg   = degree({1'b0, x}, {1'b0, y}, w_eff, h_eff, wrap_edges);
  assign div_n = cell_rd.delta[VALUE_BITS-1] ? VALUE_BITS'(-cell_rd.delta) : cell_rd.delta;

  // Neighbor of the current cell in direction k.
  logic [5:0] nbx, nby;
  assign nbx     = step_coord({1'b0, x}, w_eff, dir_dx(k[2:0]), wrap_edges);
  assign nby     = step_coord({1'b0, y}, h_eff, dir_dy(k[2:0]), wrap_edges);
  assign nb_addr = {nby[YW-1:0], nbx[XW-1:0]};

  // Update arithmetic.
  logic signed [SUM_BITS-1:0] upd_sum, upd_v, upd_d, push_sum, mx;
  assign mx      = SUM_BITS'(signed'({1'b0, mag_limit}));
  assign upd_sum = SUM_BITS'(cell_rd.value) + SUM_BITS'(cell_rd.push)
                 + SUM_BITS'(cell_rd.delta);
  always_comb begin
    if (upd_sum > mx) upd_v = mx;
    else if (upd_sum < -mx) upd_v = -mx;
    else upd_v = upd_sum;
  end
  assign upd_d    = SUM_BITS'(cell_rd.target) - upd_v;
  assign push_sum = SUM_BITS'(cell_rd.push) + SUM_BITS'(acc);

  logic in_grid;
  assign in_grid = ({1'b0, x} < w_eff) && ({1'b0, y} < h_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      x         <= '0;
      y         <= '0;
      k         <= '0;
      sv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      x     <= x_next;
      y     <= y_next;
      k     <= k_next;
      sv    <= sv_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    req   <= req_next;
    wval  <= wval_next;
    res   <= res_next;
    acc   <= acc_next;
    share <= share_next;
    dneg  <= dneg_next;
    if (out_load) read_value <= res;
  end

  assign done_res = 1'b1;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    x_next     = x;
    y_next     = y;
    k_next     = k;
    sv_next    = 1'b0;
    req_next   = req;
    wval_next  = wval;
    res_next   = res;
    acc_next   = acc;
    share_next = share;
    dneg_next  = dneg;
    cell_we    = 1'b0;
    cell_wd    = cell_rd;
    share_we   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cell_we = 1'b1;
        cell_wd = '0;
        {y_next, x_next} = {y, x} + 1'b1;
        if (last_full) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          req_next  = req_type;
          wval_next = write_value;
          res_next  = '0;
          x_next    = cell_x;
          y_next    = cell_y;
          priority case (req_type)
            REQ_WR_VALUE, REQ_WR_TARGET, REQ_RD_VALUE: state_next = ST_REQ_RD;
            REQ_UPDATE: begin
              x_next = '0;
              y_next = '0;
              state_next = ST_U_RD;
            end
            REQ_PUSH: begin
              x_next = '0;
              y_next = '0;
              state_next = ST_P1_RD;
            end
            default: state_next = ST_FIN;
          endcase
        end
      end
      ST_REQ_RD: begin
        state_next = in_grid ? ST_REQ_WB : ST_FIN;
      end
      ST_REQ_WB: begin
        if (req == REQ_WR_VALUE) begin
          cell_wd.value = wval;
          cell_we = 1'b1;
        end else if (req == REQ_WR_TARGET) begin
          cell_wd.target = wval;
          cell_we = 1'b1;
        end else begin
          res_next = cell_rd.value;
        end
        state_next = ST_FIN;
      end
      ST_U_RD: state_next = ST_U_WR;
      ST_U_WR: begin
        cell_we       = 1'b1;
        cell_wd.value = upd_v[VALUE_BITS-1:0];
        cell_wd.delta = sat_value(upd_d);
        cell_wd.push  = '0;
        x_next = x_adv;
        y_next = y_adv;
        state_next = last_active ? ST_FIN : ST_U_RD;
        if (last_active) begin
          x_next = '0;
          y_next = '0;
        end
      end
      ST_P1_RD: state_next = ST_P1_LD;
      ST_P1_LD: begin
        dneg_next = cell_rd.delta[VALUE_BITS-1];
        if (deg == 4'd0) begin
          share_next = '0;
          state_next = ST_P1_WR;
        end else begin
          div_start  = 1'b1;
          state_next = ST_P1_DIV;
        end
      end
      ST_P1_DIV: begin
        if (div_done) begin
          // Share sent is minus the delta divided by the degree, truncated toward zero.
          share_next = dneg ? SHARE_BITS'(signed'({1'b0, div_q}))
                            : -SHARE_BITS'(signed'({1'b0, div_q}));
          state_next = ST_P1_WR;
        end
      end
      ST_P1_WR: begin
        share_we = 1'b1;
        x_next = x_adv;
        y_next = y_adv;
        state_next = ST_P1_RD;
        if (last_active) begin
          x_next = '0;
          y_next = '0;
          k_next = '0;
          acc_next = '0;
          state_next = ST_P2;
        end
      end
      ST_P2: begin
        if (sv) acc_next = acc + ACC_BITS'(signed'(share_rd));
        if (k == 4'd8) begin
          state_next = ST_P2_WR;
        end else begin
          sv_next = nbx[5] && nby[5];
          k_next  = k + 1'b1;
        end
      end
      ST_P2_WR: begin
        cell_we      = 1'b1;
        cell_wd.push = sat_value(push_sum);
        x_next   = x_adv;
        y_next   = y_adv;
        k_next   = '0;
        acc_next = '0;
        state_next = last_active ? ST_FIN : ST_P2;
      end
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // No request beat during the clearing pass.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !in_ready) else $error("request taken during clear");

  // The direction counter never runs past eight, the slot of the last share.
  a_k_range: assert property (@(posedge clk) disable iff (rst)
    k <= 4'd8) else $error("direction counter overrun");

  // Share reads are only pending while gathering.
  a_sv_gather: assert property (@(posedge clk) disable iff (rst)
    sv |-> (state == ST_P2 || state == ST_P2_WR)) else $error("stray share read");

  // A result is only loaded from the finishing state.
  a_load_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FIN) else $error("result loaded out of turn");

endmodule

// ----- tb/sv/grid_neighbor_relaxation_top_tb.sv -----
// ----------------------------------------------------------------------------
// grid_neighbor_relaxation_top_tb: self-checking bench of the relaxation engine
// Drives cell writes, reads, update and push sweeps under random idling and
// several grid settings, and checks every result beat against a predictor.
// ----------------------------------------------------------------------------
module grid_neighbor_relaxation_top_tb;
  import gnr_pkg::*;

  localparam int LIMIT = 6000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] req_type = '0;
  logic [3:0] cell_x = '0;
  logic [3:0] cell_y = '0;
  logic signed [31:0] write_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] read_value;
  logic done_res;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;

  grid_neighbor_relaxation_top dut (.*);

  always #5 clk = ~clk;

  // Predictor state: a copy of the grid and registers, held wide so the
  // intermediate sums can be saturated exactly as the block does.
  typedef struct {
    logic signed [31:0] rd;
    logic done;
  } result_t;

  longint grid_val[NCELLS], grid_tgt[NCELLS], grid_dlt[NCELLS], grid_psh[NCELLS];
  longint share_acc[NCELLS];
  int unsigned reg_w = 16, reg_h = 16, reg_max = 65536, reg_wrap = 0;
  result_t pending_results[$];

  int errors = 0;
  int cycles = 0;
  bit idle_free = 1'b0;   // no random idling while set
  bit hold_off = 1'b0;    // receiver stalls on purpose while set

  localparam longint VHI = 64'sd2147483647;
  localparam longint VLO = -64'sd2147483648;

  function automatic longint clamp32(longint v);
    return v > VHI ? VHI : (v < VLO ? VLO : v);
  endfunction

  function automatic int unsigned used_size(int unsigned s);
    return s == 0 ? 1 : (s > 16 ? 16 : s);
  endfunction

  // Neighbor index of (x,y) stepped by (dx,dy), or -1 when dropped.
  function automatic int nb_index(int x, int y, int dx, int dy, int w, int h);
    int nx, ny;
    nx = x + dx;
    ny = y + dy;
    if (reg_wrap != 0) begin
      nx = (nx + w) % w;
      ny = (ny + h) % h;
    end else if (nx < 0 || nx >= w || ny < 0 || ny >= h) begin
      return -1;
    end
    return ny * MAX_WIDTH + nx;
  endfunction

  function automatic void sweep_update();
    int w, h, i;
    longint v, m;
    w = used_size(reg_w);
    h = used_size(reg_h);
    m = reg_max;
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) begin
        i = y * MAX_WIDTH + x;
        v = grid_val[i] + grid_psh[i] + grid_dlt[i];
        if (v > m) v = m;
        else if (v < -m) v = -m;
        grid_val[i] = v;
        grid_dlt[i] = clamp32(grid_tgt[i] - v);
        grid_psh[i] = 0;
      end
  endfunction

  function automatic void sweep_push();
    int w, h, nb;
    longint deg, share;
    w = used_size(reg_w);
    h = used_size(reg_h);
    foreach (share_acc[k]) share_acc[k] = 0;
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) begin
        deg = 0;
        for (int dy = -1; dy <= 1; dy++)
          for (int dx = -1; dx <= 1; dx++)
            if ((dx != 0 || dy != 0) && nb_index(x, y, dx, dy, w, h) >= 0) deg++;
        if (deg == 0) continue;
        // SystemVerilog division truncates toward zero, as needed here.
        share = -(grid_dlt[y * MAX_WIDTH + x] / deg);
        for (int dy = -1; dy <= 1; dy++)
          for (int dx = -1; dx <= 1; dx++)
            if (dx != 0 || dy != 0) begin
              nb = nb_index(x, y, dx, dy, w, h);
              if (nb >= 0) share_acc[nb] += share;
            end
      end
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        grid_psh[y * MAX_WIDTH + x] = clamp32(grid_psh[y * MAX_WIDTH + x]
                                              + share_acc[y * MAX_WIDTH + x]);
  endfunction

  // Works out the result of one accepted request and applies its effect.
  function automatic result_t predict_request(logic [2:0] rq, logic [3:0] x, logic [3:0] y,
                                              logic signed [31:0] wv);
    result_t r;
    bit in_grid;
    int i;
    in_grid = (x < used_size(reg_w)) && (y < used_size(reg_h));
    i = y * MAX_WIDTH + x;
    r.rd = '0;
    r.done = 1'b1;
    case (rq)
      REQ_WR_VALUE:  if (in_grid) grid_val[i] = wv;
      REQ_WR_TARGET: if (in_grid) grid_tgt[i] = wv;
      REQ_RD_VALUE:  if (in_grid) r.rd = 32'(grid_val[i]);
      REQ_UPDATE:    sweep_update();
      REQ_PUSH:      sweep_push();
      default: ;
    endcase
    return r;
  endfunction

  // Checker: every result beat is taken at the rising edge and compared
  // against the oldest expectation.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: read_value %0d", read_value);
        errors++;
      end else begin
        result_t e;
        e = pending_results.pop_front();
        if (read_value !== e.rd) begin
          $error("read_value expected %0d actual %0d", e.rd, read_value);
          errors++;
        end
        if (done_res !== e.done) begin
          $error("done_res expected %0d actual %0d", e.done, done_res);
          errors++;
        end
      end
    end
  end

  // Receiver: idles at random with a chance of 8 in 100, except during the
  // idle-free stretch or while a long hold-off is asked for.
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_off) out_ready <= 1'b0;
    else out_ready <= idle_free || ($urandom_range(99) >= 8);
  end

  // Timeout guard.
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("grid_neighbor_relaxation_top_tb: errors");
      $finish;
    end
  end

  // Offers one beat from a falling edge after random idling, holds it until
  // accepted, and records its expectation. The beat stays offered after
  // acceptance until the next call replaces it or drop_request withdraws it.
  // With check_rd set, the directed expected value is also compared with
  // the predictor so that typed-in rows and the model agree.
  task automatic send_request(logic [2:0] rq, logic [3:0] x, logic [3:0] y,
                              logic signed [31:0] wv, bit check_rd = 0,
                              logic signed [31:0] rd_typed = '0);
    result_t r;
    @(negedge clk);
    while (!idle_free && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    req_type <= rq;
    cell_x <= x;
    cell_y <= y;
    write_value <= wv;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = predict_request(rq, x, y, wv);
    if (check_rd && r.rd !== rd_typed) begin
      $error("read_value expected %0d actual %0d", rd_typed, r.rd);
      errors++;
    end
    pending_results.push_back(r);
  endtask

  // Withdraws the last offered beat at the next falling edge.
  task automatic drop_request();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Waits until all results are in plus a margin, then writes a register.
  task automatic write_register(logic [1:0] idx, logic [30:0] val);
    drop_request();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_WIDTH:  reg_w = val[4:0];
      CFG_HEIGHT: reg_h = val[4:0];
      CFG_MAX:    reg_max = val;
      CFG_WRAP:   reg_wrap = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_grid(int w, int h, logic [30:0] mx, bit wr);
    write_register(CFG_WIDTH, 31'(w));
    write_register(CFG_HEIGHT, 31'(h));
    write_register(CFG_MAX, mx);
    write_register(CFG_WRAP, 31'(wr));
  endtask

  // Mostly requests with in-grid addresses; writes dominate so that the
  // sweeps see varied data, with an odd unknown code now and then.
  task automatic random_request();
    logic [2:0] rq;
    logic [3:0] x, y;
    logic signed [31:0] wv;
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) rq = REQ_WR_VALUE;
    else if (pick < 55) rq = REQ_WR_TARGET;
    else if (pick < 80) rq = REQ_RD_VALUE;
    else if (pick < 88) rq = REQ_UPDATE;
    else if (pick < 95) rq = REQ_PUSH;
    else rq = 3'($urandom_range(7, 5));
    if ($urandom_range(9) < 8) begin
      x = 4'($urandom_range(used_size(reg_w) - 1));
      y = 4'($urandom_range(used_size(reg_h) - 1));
    end else begin
      x = 4'($urandom);
      y = 4'($urandom);
    end
    case ($urandom_range(3))
      0: wv = $urandom;
      1: wv = 32'($signed($urandom_range(262144)) - 131072);
      2: wv = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: wv = 32'($urandom_range(65536));
    endcase
    send_request(rq, x, y, wv);
  endtask

  typedef struct {
    logic [2:0] rq;
    logic [3:0] x, y;
    logic signed [31:0] wv;
    bit typed;
    logic signed [31:0] rd;
  } stim_row_t;

  // Directed rows: fresh reset read, extremes of value and address,
  // every request code and the unknown codes.
  stim_row_t directed_rows[] = '{
    '{REQ_RD_VALUE,  4'd0,  4'd0,  32'sd0,         1, 32'sd0},
    '{REQ_RD_VALUE,  4'd15, 4'd15, 32'sd0,         1, 32'sd0},
    '{REQ_WR_VALUE,  4'd0,  4'd0,  32'h7fffffff,   0, 32'sd0},
    '{REQ_RD_VALUE,  4'd0,  4'd0,  32'sd0,         1, 32'h7fffffff},
    '{REQ_WR_VALUE,  4'd15, 4'd15, 32'h80000000,   0, 32'sd0},
    '{REQ_RD_VALUE,  4'd15, 4'd15, 32'sd0,         1, 32'h80000000},
    '{REQ_WR_TARGET, 4'd5,  4'd7,  32'sd65536,     0, 32'sd0},
    '{REQ_WR_TARGET, 4'd15, 4'd0,  32'hffff0000,   0, 32'sd0},
    '{REQ_WR_VALUE,  4'd3,  4'd3,  32'h5555aaaa,   0, 32'sd0},
    '{REQ_UPDATE,    4'd0,  4'd0,  32'sd0,         1, 32'sd0},
    '{REQ_RD_VALUE,  4'd0,  4'd0,  32'sd0,         0, 32'sd0},
    '{REQ_RD_VALUE,  4'd15, 4'd15, 32'sd0,         0, 32'sd0},
    '{REQ_PUSH,      4'd0,  4'd0,  32'sd0,         1, 32'sd0},
    '{REQ_UPDATE,    4'd0,  4'd0,  32'sd0,         1, 32'sd0},
    '{REQ_RD_VALUE,  4'd5,  4'd7,  32'sd0,         0, 32'sd0},
    '{REQ_RD_VALUE,  4'd4,  4'd6,  32'sd0,         0, 32'sd0},
    '{3'd5,          4'd1,  4'd1,  32'sd1,         1, 32'sd0},
    '{3'd6,          4'd2,  4'd2,  32'sd2,         1, 32'sd0},
    '{3'd7,          4'd15, 4'd15, 32'hffffffff,   1, 32'sd0}
  };

  initial begin
    foreach (grid_val[k]) begin
      grid_val[k] = 0;
      grid_tgt[k] = 0;
      grid_dlt[k] = 0;
      grid_psh[k] = 0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k])
      send_request(directed_rows[k].rq, directed_rows[k].x, directed_rows[k].y,
                   directed_rows[k].wv, directed_rows[k].typed, directed_rows[k].rd);

    // Small grid: accesses beyond it are dropped or read as zero.
    set_grid(3, 2, 31'd131072, 0);
    send_request(REQ_WR_VALUE, 4'd3, 4'd0, 32'sd9, 0, 32'sd0);
    send_request(REQ_RD_VALUE, 4'd3, 4'd0, 32'sd0, 1, 32'sd0);
    send_request(REQ_RD_VALUE, 4'd0, 4'd2, 32'sd0, 1, 32'sd0);

    // Random phases over several geometries, extremes included: a single
    // isolated cell, a 1x1 torus whose neighbors are all itself, oversized
    // and zero size registers, and a zero or full magnitude limit.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_grid(1, 1, 31'd65536, 0);
        1: set_grid(1, 1, 31'h7fffffff, 1);
        2: set_grid(2, 3, 31'd0, 1);
        3: set_grid(0, 31, 31'd200000, 0);
        4: set_grid(4, 4, 31'h7fffffff, 1);
        5: set_grid(16, 16, 31'd65536, 1);
        6: set_grid(5, 2, 31'd1000000, 0);
        default: set_grid(16, 16, 31'h7fffffff, 0);
      endcase
      idle_free = (phase == 4);
      // Long receiver hold-off while the sender keeps offering beats.
      if (phase == 6)
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(negedge clk);
            hold_off = 1'b0;
          end
        join_none
      repeat (phase >= 5 ? 28 : 38) random_request();
    end
    idle_free = 1'b0;
    drop_request();

    while (pending_results.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) $display("grid_neighbor_relaxation_top_tb: clean");
    else $display("grid_neighbor_relaxation_top_tb: errors");
    $finish;
  end

endmodule

// ----- files.f -----
sv/gnr_pkg.sv
sv/gnr_ram.sv
sv/gnr_div.sv
sv/grid_neighbor_relaxation_top.sv
tb/sv/grid_neighbor_relaxation_top_tb.sv
